[hw/rtl/lca_pkg.sv]
// Shared types and constants for the lowest common ancestor block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lca_pkg;

    localparam int ID_W = 12;
    localparam logic [ID_W-1:0] DEPTH_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_A_DEP,
        S_A_LVL,
        S_A_WR,
        S_Q_SWAP,
        S_Q_UP,
        S_Q_UPJ,
        S_Q_UPW,
        S_Q_EQ,
        S_Q_LC,
        S_Q_LCW,
        S_Q_FIN,
        S_Q_FW,
        S_EMIT
    } lca_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_A_START,
        OP_A_DEPW,
        OP_A_RD,
        OP_A_WR,
        OP_Q_RD,
        OP_Q_SWAP,
        OP_Q_UPRD,
        OP_Q_UPJ,
        OP_Q_UPW,
        OP_LVL_DEC,
        OP_Q_EQ,
        OP_Q_LC,
        OP_Q_LCW,
        OP_Q_FIN,
        OP_Q_FW,
        OP_EMIT
    } lca_op_t;

    typedef struct packed {
        lca_op_t op;
    } lca_cmd_t;

    typedef struct packed {
        logic is_query;
        logic a_zero;
        logic lvl_top;
        logic lvl_zero;
        logic up_take;
        logic ab_equal;
    } lca_status_t;

endpackage

[hw/rtl/lca_in_if.sv]
// Input channel of the lowest common ancestor block: valid/ready plus one item.
// Depends on lca_pkg for the id width.
`timescale 1ns / 1ps

interface lca_in_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [lca_pkg::ID_W-1:0] node_a;
    logic [lca_pkg::ID_W-1:0] node_b;

    modport source (output valid, output mode, output node_a, output node_b, input ready);
    modport sink (input valid, input mode, input node_a, input node_b, output ready);
endinterface

[hw/rtl/lca_out_if.sv]
// Result channel of the lowest common ancestor block: valid/ready plus one item.
// Depends on lca_pkg for the id width.
`timescale 1ns / 1ps

interface lca_out_if;
    logic                     valid;
    logic                     ready;
    logic [lca_pkg::ID_W-1:0] ancestor;

    modport source (output valid, output ancestor, input ready);
    modport sink (input valid, input ancestor, output ready);
endinterface

[hw/rtl/tree_lca_binary_lifting.sv]
// Top level of the lowest common ancestor block: controller plus datapath.
// Depends on lca_pkg, lca_in_if, lca_out_if, lca_ctrl and lca_datapath.
`timescale 1ns / 1ps

// Keeps a rooted tree of up to NODES-1 nodes as a jump table of LEVELS
// power-of-two ancestors per node plus a depth per node, and answers lowest
// common ancestor queries. Attach items (mode 0) must come in parent-first
// order; the root is attached under parent 0, and node 0 is the sentinel,
// which always reads as zero, so no clearing pass is needed after reset. One
// item is worked on at a time. An attach does one jump-table read and one
// write per level through the single write port. In a query, a level of the
// lifting pass that jumps does a table read, then a depth read of the new
// node, and the second pass, skipped when the lifted nodes already meet, does
// paired table reads per level. A finished result waits in an output register
// while the next item is accepted; a query that finishes while that register
// is still full waits until its item is taken.
module tree_lca_binary_lifting #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic clk,
    input  logic rst_n,
    lca_in_if.sink    req,
    lca_out_if.source rsp
);

    lca_pkg::lca_cmd_t    cmd;
    lca_pkg::lca_status_t status;

    lca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lca_datapath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (req.mode),
        .in_node_a (req.node_a),
        .in_node_b (req.node_b),
        .ancestor  (rsp.ancestor)
    );

endmodule

[hw/rtl/lca_datapath.sv]
// Datapath: jump table and depth memories, node registers and level counter.
// Depends on lca_pkg; driven by lca_ctrl through command and status structs.
`timescale 1ns / 1ps

module lca_datapath #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lca_pkg::lca_cmd_t        cmd,
    output lca_pkg::lca_status_t     status,
    input  logic                     in_mode,
    input  logic [lca_pkg::ID_W-1:0] in_node_a,
    input  logic [lca_pkg::ID_W-1:0] in_node_b,
    output logic [lca_pkg::ID_W-1:0] ancestor
);

    localparam int ID_W  = lca_pkg::ID_W;
    localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LCW   = $clog2(LEVELS + 1);
    localparam int SUM_W = ((LEVELS > ID_W) ? LEVELS : ID_W) + 1;
    localparam int JT_DEPTH = NODES * (2 ** LW);
    localparam logic [ID_W-1:0] DEPTH_MAX_L = lca_pkg::DEPTH_MAX;

    logic [ID_W-1:0] jt_mem [JT_DEPTH];
    logic [ID_W-1:0] dep_mem [NODES];

    logic            mode_reg;
    logic [ID_W-1:0] a_reg, a_next;
    logic [ID_W-1:0] b_reg, b_next;
    logic [ID_W-1:0] da_reg, da_next;
    logic [ID_W-1:0] db_reg, db_next;
    logic [LCW-1:0]  lvl_reg, lvl_next;
    logic [ID_W-1:0] res_reg, res_next;
    logic [ID_W-1:0] ancestor_reg;

    logic [ID_W-1:0] jt_rd0_reg, jt_rd1_reg;
    logic            jt_z0_reg, jt_z1_reg;
    logic [ID_W-1:0] dep_rd0_reg, dep_rd1_reg;
    logic            dep_z0_reg, dep_z1_reg;

    logic [ID_W-1:0] jt_id0, jt_id1, dep_id0, dep_id1;
    logic [LCW-1:0]  jt_lv0;
    logic [AW+LW-1:0] jt_ra0, jt_ra1, jt_wa;
    logic            jt_we, dep_we;
    logic [ID_W-1:0] jt_wd, dep_wd;
    logic [ID_W-1:0] ua, ub, da_rd, db_rd;
    logic [SUM_W-1:0] lift_sum;

    function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] id);
        clamp_id = (32'(id) < NODES) ? id : '0;
    endfunction

    // Row and entry zero belong to the sentinel and always read as zero.
    assign ua    = jt_z0_reg ? '0 : jt_rd0_reg;
    assign ub    = jt_z1_reg ? '0 : jt_rd1_reg;
    assign da_rd = dep_z0_reg ? '0 : dep_rd0_reg;
    assign db_rd = dep_z1_reg ? '0 : dep_rd1_reg;

    assign lift_sum = SUM_W'(da_reg) + (SUM_W'(1) << lvl_reg);

    always_comb
    begin
        status.is_query = mode_reg;
        status.a_zero   = (a_reg == '0);
        status.lvl_top  = (lvl_reg == LCW'(LEVELS));
        status.lvl_zero = (lvl_reg == '0);
        status.up_take  = (lift_sum <= SUM_W'(db_reg));
        status.ab_equal = (a_reg == b_reg);
    end

    // Read and write addresses.
    always_comb
    begin
        jt_id0  = a_reg;
        jt_lv0  = lvl_reg;
        jt_id1  = b_reg;
        dep_id0 = a_reg;
        dep_id1 = b_reg;
        jt_we   = 1'b0;
        jt_wd   = ua;
        jt_wa   = {AW'(a_reg), LW'(lvl_reg)};
        dep_we  = 1'b0;
        dep_wd  = (da_rd == DEPTH_MAX_L) ? da_rd : da_rd + ID_W'(1);
        case (cmd.op)
            lca_pkg::OP_A_START:
            begin
                jt_we   = 1'b1;
                jt_wd   = b_reg;
                jt_wa   = {AW'(a_reg), LW'(0)};
                dep_id0 = b_reg;
            end
            lca_pkg::OP_A_DEPW:
            begin
                dep_we = 1'b1;
            end
            lca_pkg::OP_A_RD:
            begin
                jt_id0 = b_reg;
                jt_lv0 = lvl_reg - LCW'(1);
            end
            lca_pkg::OP_A_WR:
            begin
                jt_we = 1'b1;
            end
            lca_pkg::OP_Q_UPRD:
            begin
                jt_id0 = b_reg;
            end
            lca_pkg::OP_Q_UPJ:
            begin
                dep_id1 = ua;
            end
            lca_pkg::OP_Q_FIN:
            begin
                jt_lv0 = '0;
            end
            default:
            begin
            end
        endcase
        jt_ra0 = {AW'(jt_id0), LW'(jt_lv0)};
        jt_ra1 = {AW'(jt_id1), LW'(lvl_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (jt_we)
        begin
            jt_mem[jt_wa] <= jt_wd;
        end
        jt_rd0_reg <= jt_mem[jt_ra0];
        jt_rd1_reg <= jt_mem[jt_ra1];
        jt_z0_reg  <= (jt_id0 == '0);
        jt_z1_reg  <= (jt_id1 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[AW'(a_reg)] <= dep_wd;
        end
        dep_rd0_reg <= dep_mem[AW'(dep_id0)];
        dep_rd1_reg <= dep_mem[AW'(dep_id1)];
        dep_z0_reg  <= (dep_id0 == '0);
        dep_z1_reg  <= (dep_id1 == '0);
    end

    // Register updates.
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        da_next  = da_reg;
        db_next  = db_reg;
        lvl_next = lvl_reg;
        res_next = res_reg;
        case (cmd.op)
            lca_pkg::OP_LOAD:
            begin
                a_next = clamp_id(in_node_a);
                b_next = clamp_id(in_node_b);
            end
            lca_pkg::OP_A_START:
            begin
                lvl_next = LCW'(1);
            end
            lca_pkg::OP_A_WR:
            begin
                // During an attach the b register walks the chain of ancestors.
                b_next   = ua;
                lvl_next = lvl_reg + LCW'(1);
            end
            lca_pkg::OP_Q_SWAP:
            begin
                lvl_next = LCW'(LEVELS - 1);
                if (da_rd > db_rd)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = db_rd;
                    db_next = da_rd;
                end
                else
                begin
                    da_next = da_rd;
                    db_next = db_rd;
                end
            end
            lca_pkg::OP_Q_UPJ:
            begin
                b_next = ua;
            end
            lca_pkg::OP_Q_UPW:
            begin
                db_next = db_rd;
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - LCW'(1);
                end
            end
            lca_pkg::OP_LVL_DEC:
            begin
                lvl_next = lvl_reg - LCW'(1);
            end
            lca_pkg::OP_Q_EQ:
            begin
                res_next = a_reg;
                lvl_next = LCW'(LEVELS - 1);
            end
            lca_pkg::OP_Q_LCW:
            begin
                if (ua != ub && ua != '0 && ub != '0)
                begin
                    a_next = ua;
                    b_next = ub;
                end
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - LCW'(1);
                end
            end
            lca_pkg::OP_Q_FW:
            begin
                res_next = ua;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lvl_reg  <= '0;
        end
        else
        begin
            if (cmd.op == lca_pkg::OP_LOAD)
            begin
                mode_reg <= in_mode;
            end
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        da_reg  <= da_next;
        db_reg  <= db_next;
        res_reg <= res_next;
        if (cmd.op == lca_pkg::OP_EMIT)
        begin
            ancestor_reg <= res_reg;
        end
    end

    assign ancestor = ancestor_reg;

endmodule

[hw/rtl/lca_ctrl.sv]
// Controller: sequences attach and query items and owns the handshakes.
// Depends on lca_pkg; commands lca_datapath and reads its status.
`timescale 1ns / 1ps

module lca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lca_pkg::lca_status_t status,
    output lca_pkg::lca_cmd_t    cmd
);

    lca_pkg::lca_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    // The result register may be refilled in the cycle its item is taken.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lca_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lca_pkg::S_START;
                end
            end
            lca_pkg::S_START:
            begin
                if (status.is_query)
                begin
                    state_next = lca_pkg::S_Q_SWAP;
                end
                else if (status.a_zero)
                begin
                    state_next = lca_pkg::S_IDLE;
                end
                else
                begin
                    state_next = lca_pkg::S_A_DEP;
                end
            end
            lca_pkg::S_A_DEP:
            begin
                state_next = lca_pkg::S_A_LVL;
            end
            lca_pkg::S_A_LVL:
            begin
                state_next = status.lvl_top ? lca_pkg::S_IDLE : lca_pkg::S_A_WR;
            end
            lca_pkg::S_A_WR:
            begin
                state_next = lca_pkg::S_A_LVL;
            end
            lca_pkg::S_Q_SWAP:
            begin
                state_next = lca_pkg::S_Q_UP;
            end
            lca_pkg::S_Q_UP:
            begin
                if (status.up_take)
                begin
                    state_next = lca_pkg::S_Q_UPJ;
                end
                else if (status.lvl_zero)
                begin
                    state_next = lca_pkg::S_Q_EQ;
                end
            end
            lca_pkg::S_Q_UPJ:
            begin
                state_next = lca_pkg::S_Q_UPW;
            end
            lca_pkg::S_Q_UPW:
            begin
                state_next = status.lvl_zero ? lca_pkg::S_Q_EQ : lca_pkg::S_Q_UP;
            end
            lca_pkg::S_Q_EQ:
            begin
                state_next = status.ab_equal ? lca_pkg::S_EMIT : lca_pkg::S_Q_LC;
            end
            lca_pkg::S_Q_LC:
            begin
                state_next = lca_pkg::S_Q_LCW;
            end
            lca_pkg::S_Q_LCW:
            begin
                state_next = status.lvl_zero ? lca_pkg::S_Q_FIN : lca_pkg::S_Q_LC;
            end
            lca_pkg::S_Q_FIN:
            begin
                state_next = lca_pkg::S_Q_FW;
            end
            lca_pkg::S_Q_FW:
            begin
                state_next = lca_pkg::S_EMIT;
            end
            lca_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lca_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lca_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = lca_pkg::OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            lca_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = lca_pkg::OP_LOAD;
                end
            end
            lca_pkg::S_START:
            begin
                if (status.is_query)
                begin
                    cmd.op = lca_pkg::OP_Q_RD;
                end
                else if (!status.a_zero)
                begin
                    cmd.op = lca_pkg::OP_A_START;
                end
            end
            lca_pkg::S_A_DEP:
            begin
                cmd.op = lca_pkg::OP_A_DEPW;
            end
            lca_pkg::S_A_LVL:
            begin
                if (!status.lvl_top)
                begin
                    cmd.op = lca_pkg::OP_A_RD;
                end
            end
            lca_pkg::S_A_WR:
            begin
                cmd.op = lca_pkg::OP_A_WR;
            end
            lca_pkg::S_Q_SWAP:
            begin
                cmd.op = lca_pkg::OP_Q_SWAP;
            end
            lca_pkg::S_Q_UP:
            begin
                if (status.up_take)
                begin
                    cmd.op = lca_pkg::OP_Q_UPRD;
                end
                else if (!status.lvl_zero)
                begin
                    cmd.op = lca_pkg::OP_LVL_DEC;
                end
            end
            lca_pkg::S_Q_UPJ:
            begin
                cmd.op = lca_pkg::OP_Q_UPJ;
            end
            lca_pkg::S_Q_UPW:
            begin
                cmd.op = lca_pkg::OP_Q_UPW;
            end
            lca_pkg::S_Q_EQ:
            begin
                cmd.op = lca_pkg::OP_Q_EQ;
            end
            lca_pkg::S_Q_LC:
            begin
                cmd.op = lca_pkg::OP_Q_LC;
            end
            lca_pkg::S_Q_LCW:
            begin
                cmd.op = lca_pkg::OP_Q_LCW;
            end
            lca_pkg::S_Q_FIN:
            begin
                cmd.op = lca_pkg::OP_Q_FIN;
            end
            lca_pkg::S_Q_FW:
            begin
                cmd.op = lca_pkg::OP_Q_FW;
            end
            lca_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op = lca_pkg::OP_EMIT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == lca_pkg::OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lca_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
